>>> design/ssp_pkg.sv
package ssp_pkg;

	localparam int ADDRESS_BITS = 7;
	localparam int DATA_BITS    = 8;
	localparam int TICK_W       = 8;
	localparam int FRAME_BITS   = 1 + ADDRESS_BITS + DATA_BITS;
	localparam int SEND_BITS    = 1 + ADDRESS_BITS;
	localparam int BIT_IDX_W    = $clog2(FRAME_BITS + 1);
	localparam int SHIFT_IDX_W  = $clog2(FRAME_BITS);

	localparam logic [BIT_IDX_W-1:0] FRAME_BITS_C = BIT_IDX_W'(FRAME_BITS);
	localparam logic [BIT_IDX_W-1:0] SEND_BITS_C  = BIT_IDX_W'(SEND_BITS);
	localparam logic [SHIFT_IDX_W-1:0] LAST_BIT_C = SHIFT_IDX_W'(FRAME_BITS - 1);

	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_SETUP_TICKS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_TICKS   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_HIGH_TICKS  = 2'd2;

	localparam logic [TICK_W-1:0] SETUP_TICKS_RST = 8'd5;
	localparam logic [TICK_W-1:0] LOW_TICKS_RST   = 8'd10;
	localparam logic [TICK_W-1:0] HIGH_TICKS_RST  = 8'd10;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_SETUP = 2'd1;
	localparam logic [1:0] PH_LOW   = 2'd2;
	localparam logic [1:0] PH_HIGH  = 2'd3;

	// first member lands in the highest bits
	typedef struct packed {
		logic                  data_pin_in;
		logic [DATA_BITS-1:0]  write_data;
		logic [ADDRESS_BITS-1:0] address;
		logic                  action;
		logic                  start_req;
	} item_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] read_value;
		logic                        done_res;
		logic                        busy_res;
		logic                        data_drive_enable;
		logic                        data_out;
		logic                        serial_clock;
	} result_t;

	localparam int ITEM_W   = $bits(item_t);
	localparam int RESULT_W = $bits(result_t);
	localparam int IN_TDATA_W  = ((ITEM_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

>>> design/sensor_serial_port_master_core.sv
// channel  dir  signals                        payload
// s        in   s_tvalid s_tready s_tdata      one tick: start, direction, address, data, pin
// m        out  m_tvalid m_tready m_tdata      pin levels, busy, done, read byte
// cfg      in   cfg_we cfg_index cfg_data      tick lengths of setup, low and high phases
//
// one transfer on s gives exactly one transfer on m, from the registered output buffer.
// a new tick is taken every cycle while the skid entry is empty; timing state and the output buffer update together.
// a two-entry output buffer lets s take one more tick while m stalls.
// reset puts the port idle (clock high, data released) with default tick lengths.
module sensor_serial_port_master_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ssp_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [ssp_pkg::TICK_W-1:0]            cfg_data,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// start_req, action, address[7], write_data[8], data_pin_in, zero pad
	input  logic [ssp_pkg::IN_TDATA_W-1:0]        s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// serial_clock, data_out, data_drive_enable, busy_res, done_res, read_value[8], zero pad
	output logic [ssp_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	logic             in_fire;
	ssp_pkg::item_t   item;
	ssp_pkg::result_t res;
	ssp_pkg::result_t out_q, skid_q;
	logic             out_valid_q, skid_valid_q;

	assign item     = ssp_pkg::item_t'(s_tdata[ssp_pkg::ITEM_W-1:0]);
	assign s_tready = !skid_valid_q;
	assign in_fire  = s_tvalid && s_tready;

	ssp_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (in_fire),
		.item      (item),
		.result    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_fire;
			end
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (in_fire)
				out_q <= res;
		end else if (in_fire) begin
			skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(ssp_pkg::OUT_TDATA_W - ssp_pkg::RESULT_W){1'b0}}, out_q};

endmodule

>>> design/ssp_engine.sv
module ssp_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [ssp_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [ssp_pkg::TICK_W-1:0]            cfg_data,
	input  logic                                  step,
	input  ssp_pkg::item_t                        item,
	output ssp_pkg::result_t                      result
);

	logic [ssp_pkg::TICK_W-1:0] setup_ticks_q, low_ticks_q, high_ticks_q;

	logic [1:0]                           phase_q, phase_n;
	logic [ssp_pkg::BIT_IDX_W-1:0]        bit_idx_q, bit_idx_n, bit_idx_inc;
	logic [ssp_pkg::TICK_W-1:0]           tick_q, tick_n, plen_raw, plen;
	logic [ssp_pkg::FRAME_BITS-1:0]       out_shift_q, out_shift_n;
	logic [ssp_pkg::DATA_BITS-1:0]        in_shift_q, in_shift_n;
	logic                                 is_write_q, is_write_n;
	logic                                 old_drv, new_drv, done;
	logic [ssp_pkg::DATA_BITS-1:0]        rv;
	logic [ssp_pkg::SHIFT_IDX_W-1:0]      sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_ticks_q <= ssp_pkg::SETUP_TICKS_RST;
			low_ticks_q   <= ssp_pkg::LOW_TICKS_RST;
			high_ticks_q  <= ssp_pkg::HIGH_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ssp_pkg::REG_SETUP_TICKS: setup_ticks_q <= cfg_data;
				ssp_pkg::REG_LOW_TICKS:   low_ticks_q   <= cfg_data;
				ssp_pkg::REG_HIGH_TICKS:  high_ticks_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (phase_q)
			ssp_pkg::PH_SETUP: plen_raw = setup_ticks_q;
			ssp_pkg::PH_LOW:   plen_raw = low_ticks_q;
			default:           plen_raw = high_ticks_q;
		endcase
		plen = (plen_raw == '0) ? ssp_pkg::TICK_W'(1) : plen_raw;
	end

	assign old_drv     = is_write_q || (bit_idx_q < ssp_pkg::SEND_BITS_C);
	assign bit_idx_inc = bit_idx_q + ssp_pkg::BIT_IDX_W'(1);

	always_comb begin
		phase_n     = phase_q;
		bit_idx_n   = bit_idx_q;
		tick_n      = tick_q;
		out_shift_n = out_shift_q;
		in_shift_n  = in_shift_q;
		is_write_n  = is_write_q;
		done        = 1'b0;
		rv          = '0;
		if (phase_q == ssp_pkg::PH_IDLE) begin
			if (item.start_req) begin
				is_write_n  = item.action;
				out_shift_n = {item.action, item.address, item.write_data};
				in_shift_n  = '0;
				bit_idx_n   = '0;
				phase_n     = ssp_pkg::PH_SETUP;
				tick_n      = ssp_pkg::TICK_W'(1);
			end
		end else if (tick_q < plen) begin
			tick_n = tick_q + ssp_pkg::TICK_W'(1);
		end else begin
			tick_n = ssp_pkg::TICK_W'(1);
			case (phase_q)
				ssp_pkg::PH_SETUP: phase_n = ssp_pkg::PH_LOW;
				ssp_pkg::PH_LOW:   phase_n = ssp_pkg::PH_HIGH;
				default: begin
					if (!old_drv)
						in_shift_n = {in_shift_q[ssp_pkg::DATA_BITS-2:0], item.data_pin_in};
					bit_idx_n = bit_idx_inc;
					if (bit_idx_inc >= ssp_pkg::FRAME_BITS_C) begin
						done      = 1'b1;
						rv        = is_write_q ? '0 : in_shift_n;
						phase_n   = ssp_pkg::PH_IDLE;
						bit_idx_n = '0;
						tick_n    = '0;
					end else begin
						phase_n = ssp_pkg::PH_SETUP;
					end
				end
			endcase
		end
	end

	// output levels reflect the state after this tick
	assign new_drv = is_write_n || (bit_idx_n < ssp_pkg::SEND_BITS_C);
	assign sh      = ssp_pkg::LAST_BIT_C - bit_idx_n[ssp_pkg::SHIFT_IDX_W-1:0];

	always_comb begin
		result.done_res   = done;
		result.read_value = rv;
		if (phase_n == ssp_pkg::PH_IDLE) begin
			result.serial_clock      = 1'b1;
			result.data_out          = 1'b0;
			result.data_drive_enable = 1'b0;
			result.busy_res          = 1'b0;
		end else begin
			result.serial_clock      = (phase_n != ssp_pkg::PH_LOW);
			result.data_out          = new_drv & out_shift_n[sh];
			result.data_drive_enable = new_drv;
			result.busy_res          = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= ssp_pkg::PH_IDLE;
			bit_idx_q   <= '0;
			tick_q      <= '0;
			out_shift_q <= '0;
			in_shift_q  <= '0;
			is_write_q  <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_n;
			bit_idx_q   <= bit_idx_n;
			tick_q      <= tick_n;
			out_shift_q <= out_shift_n;
			in_shift_q  <= in_shift_n;
			is_write_q  <= is_write_n;
		end
	end

endmodule

>>> design/ssp_checker.sv
module ssp_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [ssp_pkg::OUT_TDATA_W-1:0]       m_tdata
);

	// stalled transfer holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled output transfer changed");

	// frame end leaves the port idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[0] && !m_tdata[3] && !m_tdata[2])
		else $error("done without idle pin levels");

	a_data_driven: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[2] && m_tdata[3])
		else $error("data level high while released or idle");

	a_read_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[12:5] == 8'd0)
		else $error("read value outside a done transfer");

endmodule

bind sensor_serial_port_master_core ssp_checker u_ssp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

>>> sim/tb_sensor_serial_port_master_core.sv
module tb_sensor_serial_port_master_core;

	localparam logic [ssp_pkg::CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
	localparam int LIMIT_CYCLES = 600000;
	localparam int SETTLE_CYCLES = 6;
	localparam int PIN_LOW = 0;
	localparam int PIN_HIGH = 1;
	localparam int PIN_RANDOM = 2;
	localparam int PHASE_TICKS = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [ssp_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [ssp_pkg::TICK_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [ssp_pkg::IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [ssp_pkg::OUT_TDATA_W-1:0] m_tdata;

	int idle_pct = 0;
	int stall_pct = 0;
	int errors = 0;
	int cycles = 0;
	int ticks_sent = 0;

	// port model state
	logic [ssp_pkg::TICK_W-1:0] setup_len = ssp_pkg::SETUP_TICKS_RST;
	logic [ssp_pkg::TICK_W-1:0] low_len = ssp_pkg::LOW_TICKS_RST;
	logic [ssp_pkg::TICK_W-1:0] high_len = ssp_pkg::HIGH_TICKS_RST;
	logic [1:0] port_phase = ssp_pkg::PH_IDLE;
	logic [ssp_pkg::BIT_IDX_W-1:0] bit_cnt = '0;
	logic [ssp_pkg::TICK_W-1:0] tick_cnt = '0;
	logic [ssp_pkg::FRAME_BITS-1:0] frame_word = '0;
	logic [ssp_pkg::DATA_BITS-1:0] rx_byte = '0;
	logic wr_frame = 1'b0;

	ssp_pkg::result_t expected_pins[$];

	sensor_serial_port_master_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_sensor_serial_port_master_core: errors");
			$finish;
		end
	end

	always @(posedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	// advance the port by one tick and return the pin levels after it
	function automatic ssp_pkg::result_t sensor_port_tick(input ssp_pkg::item_t it);
		ssp_pkg::result_t r;
		logic [ssp_pkg::TICK_W-1:0] len;
		logic drv;
		r = '0;
		if (port_phase == ssp_pkg::PH_IDLE) begin
			if (it.start_req) begin
				wr_frame = it.action;
				frame_word = {it.action, it.address, it.write_data};
				rx_byte = '0;
				bit_cnt = '0;
				port_phase = ssp_pkg::PH_SETUP;
				tick_cnt = ssp_pkg::TICK_W'(1);
			end
		end else begin
			len = (port_phase == ssp_pkg::PH_SETUP) ? setup_len :
				(port_phase == ssp_pkg::PH_LOW) ? low_len : high_len;
			if (len == '0)
				len = ssp_pkg::TICK_W'(1);
			if (tick_cnt < len) begin
				tick_cnt++;
			end else begin
				tick_cnt = ssp_pkg::TICK_W'(1);
				case (port_phase)
					ssp_pkg::PH_SETUP: port_phase = ssp_pkg::PH_LOW;
					ssp_pkg::PH_LOW: port_phase = ssp_pkg::PH_HIGH;
					default: begin
						if (!(wr_frame || bit_cnt < ssp_pkg::SEND_BITS_C))
							rx_byte = {rx_byte[ssp_pkg::DATA_BITS-2:0], it.data_pin_in};
						bit_cnt++;
						if (bit_cnt >= ssp_pkg::FRAME_BITS_C) begin
							r.done_res = 1'b1;
							r.read_value = wr_frame ? '0 : rx_byte;
							port_phase = ssp_pkg::PH_IDLE;
							bit_cnt = '0;
							tick_cnt = '0;
						end else begin
							port_phase = ssp_pkg::PH_SETUP;
						end
					end
				endcase
			end
		end
		if (port_phase == ssp_pkg::PH_IDLE) begin
			r.serial_clock = 1'b1;
		end else begin
			drv = wr_frame || bit_cnt < ssp_pkg::SEND_BITS_C;
			r.serial_clock = (port_phase != ssp_pkg::PH_LOW);
			r.data_out = drv ? frame_word[ssp_pkg::FRAME_BITS - 1 - int'(bit_cnt)] : 1'b0;
			r.data_drive_enable = drv;
			r.busy_res = 1'b1;
		end
		return r;
	endfunction

	task automatic flag_error(input string msg);
		errors++;
		if (errors <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk) begin
		ssp_pkg::result_t got;
		ssp_pkg::result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = ssp_pkg::result_t'(m_tdata[ssp_pkg::RESULT_W-1:0]);
			if (expected_pins.size() == 0) begin
				flag_error($sformatf("unexpected transfer on m: %h", got));
			end else begin
				want = expected_pins.pop_front();
				if (got.serial_clock !== want.serial_clock ||
					got.data_out !== want.data_out ||
					got.data_drive_enable !== want.data_drive_enable ||
					got.busy_res !== want.busy_res ||
					got.done_res !== want.done_res ||
					got.read_value !== want.read_value)
					flag_error($sformatf(
						"mismatch: clk/dout/den/busy/done/rd exp %b%b%b%b%b %0d got %b%b%b%b%b %0d",
						want.serial_clock, want.data_out, want.data_drive_enable,
						want.busy_res, want.done_res, want.read_value,
						got.serial_clock, got.data_out, got.data_drive_enable,
						got.busy_res, got.done_res, got.read_value));
			end
		end
	end

	task automatic send_tick(input ssp_pkg::item_t it);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ssp_pkg::IN_TDATA_W'(it);
		do @(posedge clk); while (!s_tready);
		expected_pins.push_back(sensor_port_tick(it));
		ticks_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_pins.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_ticks(input logic [ssp_pkg::TICK_W-1:0] su, lo, hi,
		input bit poke_spare);
		logic [ssp_pkg::TICK_W-1:0] vals [4];
		logic [ssp_pkg::CFG_INDEX_W-1:0] idx [4];
		int n;
		drain();
		vals = '{su, lo, hi, ssp_pkg::TICK_W'($urandom)};
		idx = '{ssp_pkg::REG_SETUP_TICKS, ssp_pkg::REG_LOW_TICKS, ssp_pkg::REG_HIGH_TICKS,
			REG_SPARE};
		n = poke_spare ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			@(posedge clk);
			case (idx[i])
				ssp_pkg::REG_SETUP_TICKS: setup_len = vals[i];
				ssp_pkg::REG_LOW_TICKS: low_len = vals[i];
				ssp_pkg::REG_HIGH_TICKS: high_len = vals[i];
				default: ;
			endcase
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic pin_level(input int mode);
		if (mode == PIN_LOW)
			return 1'b0;
		if (mode == PIN_HIGH)
			return 1'b1;
		return logic'($urandom_range(1));
	endfunction

	function automatic ssp_pkg::item_t any_item();
		return ssp_pkg::item_t'(ssp_pkg::ITEM_W'($urandom));
	endfunction

	// one start tick, then ticks until the frame is over
	task automatic run_frame(input logic act, input logic [ssp_pkg::ADDRESS_BITS-1:0] addr,
		input logic [ssp_pkg::DATA_BITS-1:0] data, input int pin_mode, input int noise_pct);
		ssp_pkg::item_t it;
		it = any_item();
		it.start_req = 1'b1;
		it.action = act;
		it.address = addr;
		it.write_data = data;
		it.data_pin_in = pin_level(pin_mode);
		send_tick(it);
		while (port_phase != ssp_pkg::PH_IDLE) begin
			it = any_item();
			it.start_req = ($urandom_range(99) < noise_pct);
			it.data_pin_in = pin_level(pin_mode);
			send_tick(it);
		end
	endtask

	function automatic logic [ssp_pkg::TICK_W-1:0] pick_ticks();
		int r;
		r = $urandom_range(19);
		if (r == 0)
			return '0;
		if (r == 1)
			return ssp_pkg::TICK_W'($urandom_range(5, 24));
		return ssp_pkg::TICK_W'($urandom_range(1, 3));
	endfunction

	task automatic test_reset_defaults();
		ssp_pkg::item_t it;
		it = '1;
		it.start_req = 1'b0;
		send_tick(it);
		send_tick('0);
		run_frame(1'b1, 7'h55, 8'hA5, PIN_RANDOM, 0);
		drain();
	endtask

	task automatic test_short_phases();
		// zero lengths act as one tick
		program_ticks(8'd0, 8'd0, 8'd0, 1'b1);
		run_frame(1'b1, 7'h7F, 8'hFF, PIN_RANDOM, 100);
		run_frame(1'b1, 7'h00, 8'h00, PIN_RANDOM, 0);
		run_frame(1'b0, 7'h7F, 8'hFF, PIN_HIGH, 100);
		run_frame(1'b0, 7'h00, 8'h00, PIN_LOW, 0);
		run_frame(1'b0, 7'h2A, 8'h5A, PIN_RANDOM, 50);
		program_ticks(8'd1, 8'd2, 8'd3, 1'b0);
		run_frame(1'b0, 7'h41, 8'h3C, PIN_RANDOM, 20);
		run_frame(1'b1, 7'h1E, 8'hC3, PIN_RANDOM, 20);
		drain();
	endtask

	task automatic test_long_phases();
		program_ticks(8'd6, 8'd4, 8'd3, 1'b0);
		run_frame(1'b0, 7'($urandom), 8'($urandom), PIN_RANDOM, 30);
		drain();
	endtask

	task automatic test_random_traffic();
		int idle_set [4];
		int stall_set [4];
		int start_cnt;
		ssp_pkg::item_t it;
		idle_set = '{0, 64, 0, 17};
		stall_set = '{0, 0, 64, 17};
		for (int m = 0; m < 4; m++) begin
			program_ticks(pick_ticks(), pick_ticks(), pick_ticks(), 1'b1);
			idle_pct = idle_set[m];
			stall_pct = stall_set[m];
			start_cnt = ticks_sent;
			while (ticks_sent - start_cnt < PHASE_TICKS) begin
				if ($urandom_range(99) < 85) begin
					run_frame(logic'($urandom_range(1)), 7'($urandom), 8'($urandom),
						PIN_RANDOM, $urandom_range(100));
				end else begin
					repeat ($urandom_range(1, 8)) begin
						it = any_item();
						it.start_req = 1'b0;
						send_tick(it);
					end
				end
			end
			drain();
			idle_pct = 0;
			stall_pct = 0;
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_short_phases();
		test_long_phases();
		test_random_traffic();
		drain();
		repeat (8) @(posedge clk);
		if (expected_pins.size() != 0)
			errors++;
		if (errors == 0)
			$display("tb_sensor_serial_port_master_core: clean");
		else
			$display("tb_sensor_serial_port_master_core: errors");
		$finish;
	end

endmodule

>>> sensor_serial_port_master_core.f
design/ssp_pkg.sv
design/ssp_engine.sv
design/sensor_serial_port_master_core.sv
design/ssp_checker.sv
sim/tb_sensor_serial_port_master_core.sv
